### hdl/hsfrc_pkg.sv
// Shared types and constants for the HVAC sensor fault rule checker.
`default_nettype none

package hsfrc_pkg;

	// Depth of the CO2 history and the saturating row count.
	localparam int HIST_DEPTH = 4;
	localparam int ROWS_W     = 3;
	localparam logic [ROWS_W-1:0] ROWS_FULL = 3'd4;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int THR_W      = 16;
	localparam int PIR_W      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CO2_LOW        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CO2_HIGH       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_LOW       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_HIGH      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_INTERVAL = 3'd4;

	// Reset values of the threshold registers.
	localparam logic [THR_W-1:0] CO2_LOW_RST  = 16'd418;
	localparam logic [THR_W-1:0] CO2_HIGH_RST = 16'd630;
	localparam logic [THR_W-1:0] FLOW_LOW_RST = 16'd7;
	localparam logic [THR_W-1:0] FLOW_HIGH_RST = 16'd70;

	// Result beat width: nine flags padded to whole bytes.
	localparam int FLAG_W  = 9;
	localparam int M_DATA_W = 16;

	// Threshold and mode settings.
	typedef struct packed {
		logic [THR_W-1:0] co2_low;
		logic [THR_W-1:0] co2_high;
		logic [THR_W-1:0] flow_low;
		logic [THR_W-1:0] flow_high;
		logic             short_interval;
	} cfg_t;

	// Fault flags; the last member lands in bit 0.
	typedef struct packed {
		logic pir_bad;
		logic co2_jump;
		logic co2_frozen;
		logic co2_too_low;
		logic co2_too_high;
		logic pir_flow_mismatch;
		logic flow_frozen;
		logic flow_too_low;
		logic flow_too_high;
	} flag_t;

endpackage

`default_nettype wire

### hdl/hsfrc_eval.sv
// Combinational fault rules for one sensor row against the kept history.
`default_nettype none

module hsfrc_eval #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire hsfrc_pkg::cfg_t                                  cfg,
	input  wire                                                   starts_set,
	input  wire [SAMPLE_BITS-1:0]                                 co2_sample,
	input  wire                                                   co2_present,
	input  wire [SAMPLE_BITS-1:0]                                 flow_sample,
	input  wire                                                   flow_present,
	input  wire [hsfrc_pkg::PIR_W-1:0]                            pir_sample,
	input  wire                                                   pir_present,
	input  wire [hsfrc_pkg::HIST_DEPTH-1:0][SAMPLE_BITS-1:0]      co2_hist,
	input  wire [hsfrc_pkg::HIST_DEPTH-1:0]                       co2_hist_vld,
	input  wire [SAMPLE_BITS-1:0]                                 last_flow,
	input  wire                                                   last_flow_vld,
	input  wire [hsfrc_pkg::ROWS_W-1:0]                           rows_seen,
	output hsfrc_pkg::flag_t                                      flags,
	output logic [hsfrc_pkg::ROWS_W-1:0]                          rows_next
);
	import hsfrc_pkg::*;

	// Compare width covers both the samples and the 16-bit thresholds.
	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	logic [HIST_DEPTH-1:0] vld_eff;
	logic [ROWS_W-1:0]     rows_eff;
	logic [CMP_W-1:0]      co2_x;
	logic [CMP_W-1:0]      flow_x;
	logic [SAMPLE_BITS-1:0] prev;
	logic [SAMPLE_BITS-1:0] diff;
	logic [SAMPLE_BITS+3:0] diff_x10;
	logic [SAMPLE_BITS+3:0] lim;
	logic                  in_band;
	logic                  all4;
	logic                  same4;
	logic                  c_lo;
	logic                  f_hi;

	// A new data set hides all history before this row is judged.
	assign vld_eff  = starts_set ? '0 : co2_hist_vld;
	assign rows_eff = starts_set ? '0 : rows_seen;
	assign rows_next = (rows_eff == ROWS_FULL) ? ROWS_FULL : rows_eff + 1'b1;

	assign co2_x  = CMP_W'(co2_sample);
	assign flow_x = CMP_W'(flow_sample);

	// Band test: |v - p| <= round(p / 10) is the same as 10 * |v - p| <= p + 5.
	assign prev     = co2_hist[0];
	assign diff     = (co2_sample >= prev) ? co2_sample - prev : prev - co2_sample;
	assign diff_x10 = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0};
	assign lim      = (SAMPLE_BITS + 4)'(prev) + (SAMPLE_BITS + 4)'(5);
	assign in_band  = diff_x10 <= lim;

	// Four-row frozen test inputs.
	assign all4  = cfg.short_interval & (&vld_eff);
	always_comb begin
		same4 = 1'b1;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			same4 = same4 & (co2_hist[k] == co2_sample);
		end
	end

	assign c_lo = co2_x <= CMP_W'(cfg.co2_low);
	assign f_hi = flow_x >= CMP_W'(cfg.flow_high);

	// CO2 rules.
	always_comb begin
		flags = '1;
		if (co2_present) begin
			flags.co2_too_low  = c_lo;
			flags.co2_too_high = !c_lo && (co2_x >= CMP_W'(cfg.co2_high));
			if (rows_eff >= ROWS_FULL) begin
				if (all4) begin
					flags.co2_frozen = same4;
				end else if (vld_eff[0]) begin
					flags.co2_frozen = (prev == co2_sample);
				end else begin
					flags.co2_frozen = 1'b1;
				end
			end else begin
				flags.co2_frozen = 1'b0;
			end
			if (rows_eff != '0) begin
				flags.co2_jump = vld_eff[0] ? !in_band : 1'b1;
			end else begin
				flags.co2_jump = 1'b0;
			end
		end

		// Airflow rules.
		if (flow_present) begin
			flags.flow_too_high = f_hi;
			flags.flow_too_low  = !f_hi && (flow_x <= CMP_W'(cfg.flow_low));
			if (rows_eff != '0) begin
				if (last_flow_vld && !starts_set && co2_present && vld_eff[0]) begin
					flags.flow_frozen = in_band && (flow_sample == last_flow);
				end else begin
					flags.flow_frozen = 1'b1;
				end
			end else begin
				flags.flow_frozen = 1'b0;
			end
		end

		// Presence rules.
		if (pir_present) begin
			if (flow_present) begin
				flags.pir_flow_mismatch = (pir_sample != '0) != (flow_sample != '0);
			end else begin
				flags.pir_flow_mismatch = 1'b1;
			end
			flags.pir_bad = pir_sample > PIR_W'(1);
		end
	end

endmodule

`default_nettype wire

### hdl/hvac_sensor_fault_rule_checker_core.sv
// HVAC sensor fault rule checker: top level with row register, history and result register.
//
// One input beat on the s_ side is one sensor row (CO2, airflow, PIR, each with a
// present bit); s_tuser carries the start-of-set mark. Each row gives exactly one
// result beat on the m_ side with nine fault flags, 1 meaning fault.
// A result beat shows on m_tvalid once its row moves on into the result register;
// the row register and the result register form two stages. Throughput is one
// row per cycle while m_tready stays high: the rule logic sits between the row
// register and the result register, and the history updates at the same edge as
// the result register loads, so back-to-back rows see each other.
// When the receiver stalls, the result register holds its beat and the row
// register takes one more beat; s_tready then drops until m_tready returns.
// The cfg_ port writes thresholds and the interval mode by register index; write
// it only while no row is in flight.
// Reset clears both valid stages, the history valid bits and the row count,
// loads the thresholds with their default values and sets the short-interval mode.
`default_nettype none

module hvac_sensor_fault_rule_checker_core #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// Input rows.
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	// Low to high: co2_sample, co2_present, flow_sample, flow_present,
	// pir_sample, pir_present, zero pad.
	input  wire [((2*SAMPLE_BITS+11+7)/8)*8-1:0]  s_tdata,
	// starts_set.
	input  wire                                   s_tuser,
	// Result flags.
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// Low to high: flow_too_high, flow_too_low, flow_frozen, pir_flow_mismatch,
	// co2_too_high, co2_too_low, co2_frozen, co2_jump, pir_bad, zero pad.
	output logic [hsfrc_pkg::M_DATA_W-1:0]        m_tdata,
	// Register writes.
	input  wire                                   cfg_we,
	input  wire [hsfrc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [hsfrc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import hsfrc_pkg::*;

	localparam int CO2_LSB   = 0;
	localparam int CO2P_BIT  = SAMPLE_BITS;
	localparam int FLOW_LSB  = SAMPLE_BITS + 1;
	localparam int FLOWP_BIT = 2*SAMPLE_BITS + 1;
	localparam int PIR_LSB   = 2*SAMPLE_BITS + 2;
	localparam int PIRP_BIT  = 2*SAMPLE_BITS + PIR_W + 2;

	cfg_t                                cfg_q;

	logic                                valid_s1;
	logic                                starts_s1;
	logic [SAMPLE_BITS-1:0]              co2_s1;
	logic                                co2p_s1;
	logic [SAMPLE_BITS-1:0]              flow_s1;
	logic                                flowp_s1;
	logic [PIR_W-1:0]                    pir_s1;
	logic                                pirp_s1;

	logic [HIST_DEPTH-1:0][SAMPLE_BITS-1:0] co2_hist_q;
	logic [HIST_DEPTH-1:0]               co2_hist_vld_q;
	logic [SAMPLE_BITS-1:0]              last_flow_q;
	logic                                last_flow_vld_q;
	logic [ROWS_W-1:0]                   rows_q;

	flag_t                               flags;
	flag_t                               flags_q;
	logic [ROWS_W-1:0]                   rows_next;
	logic                                advance;

	// The row moves on when the result register is empty or being drained.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.co2_low        <= CO2_LOW_RST;
			cfg_q.co2_high       <= CO2_HIGH_RST;
			cfg_q.flow_low       <= FLOW_LOW_RST;
			cfg_q.flow_high      <= FLOW_HIGH_RST;
			cfg_q.short_interval <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CO2_LOW: begin
					cfg_q.co2_low <= cfg_wdata;
				end
				REG_CO2_HIGH: begin
					cfg_q.co2_high <= cfg_wdata;
				end
				REG_FLOW_LOW: begin
					cfg_q.flow_low <= cfg_wdata;
				end
				REG_FLOW_HIGH: begin
					cfg_q.flow_high <= cfg_wdata;
				end
				REG_SHORT_INTERVAL: begin
					cfg_q.short_interval <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Row register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Row register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			starts_s1 <= s_tuser;
			co2_s1    <= s_tdata[CO2_LSB +: SAMPLE_BITS];
			co2p_s1   <= s_tdata[CO2P_BIT];
			flow_s1   <= s_tdata[FLOW_LSB +: SAMPLE_BITS];
			flowp_s1  <= s_tdata[FLOWP_BIT];
			pir_s1    <= s_tdata[PIR_LSB +: PIR_W];
			pirp_s1   <= s_tdata[PIRP_BIT];
		end
	end

	// Fault rules.
	hsfrc_eval #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_eval (
		.cfg          (cfg_q),
		.starts_set   (starts_s1),
		.co2_sample   (co2_s1),
		.co2_present  (co2p_s1),
		.flow_sample  (flow_s1),
		.flow_present (flowp_s1),
		.pir_sample   (pir_s1),
		.pir_present  (pirp_s1),
		.co2_hist     (co2_hist_q),
		.co2_hist_vld (co2_hist_vld_q),
		.last_flow    (last_flow_q),
		.last_flow_vld(last_flow_vld_q),
		.rows_seen    (rows_q),
		.flags        (flags),
		.rows_next    (rows_next)
	);

	// History valid bits and row count advance with each judged row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			co2_hist_vld_q  <= '0;
			last_flow_vld_q <= 1'b0;
			rows_q          <= '0;
		end else if (advance) begin
			co2_hist_vld_q  <= {(starts_s1 ? {(HIST_DEPTH-1){1'b0}}
				: co2_hist_vld_q[HIST_DEPTH-2:0]), co2p_s1};
			last_flow_vld_q <= flowp_s1;
			rows_q          <= rows_next;
		end
	end

	// History samples shift in every judged row, valid or not.
	always_ff @(posedge clk) begin
		if (advance) begin
			co2_hist_q  <= {co2_hist_q[HIST_DEPTH-2:0], co2_s1};
			last_flow_q <= flow_s1;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			flags_q <= flags;
		end
	end

	assign m_tdata = {(M_DATA_W - FLAG_W)'(0), flags_q};

endmodule

`default_nettype wire
